[src/pgt_pkg.sv]
// package for the pinch gesture tracker
// shared widths, event codes, queue entry and back-end state types
package pgt_pkg;

    localparam int CoordWidth = 16;
    localparam int IdWidth = 8;
    localparam int ScaleFracBits = 8;
    localparam int ScaleWidth = 16;
    localparam int DeltaWidth = CoordWidth + 1;
    localparam int SqWidth = 2 * DeltaWidth + 1;
    localparam int QuotWidth = 33;
    localparam int DivSteps = SqWidth + 2 * ScaleFracBits;
    localparam int DivCntWidth = $clog2(DivSteps + 1);
    localparam int RootSteps = 16;
    localparam int RootCntWidth = $clog2(RootSteps + 1);
    localparam logic [ScaleWidth-1:0] ScaleMax = '1;

    typedef enum logic [1:0] {
        MODE_MOVE   = 2'd0,
        MODE_END    = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        JOB_SCALE = 2'd0,
        JOB_ENDED = 2'd1
    } t_job_kind;

    typedef struct packed {
        t_job_kind                     kind;
        logic signed [CoordWidth-1:0]  cx;
        logic signed [CoordWidth-1:0]  cy;
        logic        [SqWidth-1:0]     cur_sq;
        logic        [SqWidth-1:0]     last_sq;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_ROOT = 2'd2,
        ST_OUT  = 2'd3
    } t_back_state;

endpackage

[src/pgt_front.sv]
// front end: slot tracking, event classification, job issue
// depends on pgt_pkg
module pgt_front import pgt_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic [3:0]                   i_touch_count,
    input  logic [IdWidth-1:0]           i_first_id,
    input  logic signed [CoordWidth-1:0] i_first_x,
    input  logic signed [CoordWidth-1:0] i_first_y,
    input  logic [IdWidth-1:0]           i_second_id,
    input  logic signed [CoordWidth-1:0] i_second_x,
    input  logic signed [CoordWidth-1:0] i_second_y,
    output logic                         o_job_valid,
    input  logic                         i_job_full,
    output t_job                         o_job
);

    logic [1:0]                   r_valid;
    logic [IdWidth-1:0]           r_id [2];
    logic signed [CoordWidth-1:0] r_x [2];
    logic signed [CoordWidth-1:0] r_y [2];

    logic a_hit, b_hit, a_sel, b_sel, accept, end_hit;
    logic signed [DeltaWidth-1:0] ldx, ldy, cdx, cdy;
    logic [DeltaWidth-1:0] aldx, aldy, acdx, acdy;
    logic [2*DeltaWidth-1:0] plx, ply, pcx, pcy;
    logic [SqWidth-1:0] last_sq, cur_sq;
    logic signed [DeltaWidth-1:0] sx, sy;
    t_mode mode;

    function automatic logic [DeltaWidth-1:0] absv(input logic signed [DeltaWidth-1:0] v);
        absv = v[DeltaWidth-1] ? DeltaWidth'(-v) : DeltaWidth'(v);
    endfunction

    always_comb begin
        mode   = t_mode'(i_mode);
        o_stall = i_job_full;
        accept = i_valid && !i_job_full;
        a_sel  = !(r_valid[0] && r_id[0] == i_first_id);
        a_hit  = (r_valid[0] && r_id[0] == i_first_id) || (r_valid[1] && r_id[1] == i_first_id);
        b_sel  = !(r_valid[0] && r_id[0] == i_second_id);
        b_hit  = (r_valid[0] && r_id[0] == i_second_id) ||
                 (r_valid[1] && r_id[1] == i_second_id);
        end_hit = a_hit;
        ldx = DeltaWidth'(r_x[a_sel]) - DeltaWidth'(r_x[b_sel]);
        ldy = DeltaWidth'(r_y[a_sel]) - DeltaWidth'(r_y[b_sel]);
        cdx = DeltaWidth'(i_first_x) - DeltaWidth'(i_second_x);
        cdy = DeltaWidth'(i_first_y) - DeltaWidth'(i_second_y);
        aldx = absv(ldx);
        aldy = absv(ldy);
        acdx = absv(cdx);
        acdy = absv(cdy);
        plx = (2*DeltaWidth)'(aldx) * (2*DeltaWidth)'(aldx);
        ply = (2*DeltaWidth)'(aldy) * (2*DeltaWidth)'(aldy);
        pcx = (2*DeltaWidth)'(acdx) * (2*DeltaWidth)'(acdx);
        pcy = (2*DeltaWidth)'(acdy) * (2*DeltaWidth)'(acdy);
        last_sq = SqWidth'(plx) + SqWidth'(ply);
        cur_sq  = SqWidth'(pcx) + SqWidth'(pcy);
        sx = DeltaWidth'(i_first_x) + DeltaWidth'(i_second_x);
        sy = DeltaWidth'(i_first_y) + DeltaWidth'(i_second_y);
        o_job.cx = sx[DeltaWidth-1:1];
        o_job.cy = sy[DeltaWidth-1:1];
        o_job.cur_sq = cur_sq;
        o_job.last_sq = last_sq;
        o_job.kind = (mode == MODE_END) ? JOB_ENDED : JOB_SCALE;
        o_job_valid = 1'b0;
        if (accept) begin
            case (mode)
                MODE_MOVE: o_job_valid = (i_touch_count == 4'd2) && a_hit && b_hit &&
                                         last_sq != '0 && cur_sq != '0;
                MODE_END:  o_job_valid = end_hit;
                default:   o_job_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (accept) begin
            case (mode)
                MODE_MOVE: begin
                    if (i_touch_count == 4'd2) begin
                        if (a_hit && b_hit && (last_sq == '0 || cur_sq == '0)) begin
                            r_valid <= '0;
                        end else begin
                            r_valid <= 2'b11;
                        end
                    end
                end
                MODE_END:    r_valid <= '0;
                MODE_CANCEL: r_valid <= '0;
                default:     r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && mode == MODE_MOVE && i_touch_count == 4'd2) begin
            r_id[0] <= i_first_id;
            r_x[0]  <= i_first_x;
            r_y[0]  <= i_first_y;
            r_id[1] <= i_second_id;
            r_x[1]  <= i_second_x;
            r_y[1]  <= i_second_y;
        end
    end

`ifndef ASSERT_OFF
    a_cancel_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && mode == MODE_CANCEL) |=> r_valid == '0)
        else $error("cancel did not clear slots");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && mode == MODE_END) |=> r_valid == '0)
        else $error("end did not clear slots");
    a_job_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> accept)
        else $error("job issued without item");
`endif

endmodule

[src/pgt_queue.sv]
// two-entry job queue between front and back
// depends on pgt_pkg
module pgt_queue import pgt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    output logic o_nonempty,
    input  logic i_pop,
    output t_job o_data
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign push = i_push && r_cnt != 2'd2;
    assign pop  = i_pop && r_cnt != 2'd0;
    assign o_full = r_cnt == 2'd2;
    assign o_nonempty = r_cnt != 2'd0;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count slip");
`endif

endmodule

[src/pgt_back.sv]
// back end: restoring divide, integer square root, result register
// depends on pgt_pkg
module pgt_back import pgt_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  t_job                         i_job,
    output logic                         o_job_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_gesture_phase,
    output logic signed [CoordWidth-1:0] o_center_x,
    output logic signed [CoordWidth-1:0] o_center_y,
    output logic [ScaleWidth-1:0]        o_scale
);

    t_back_state r_state, n_state;
    logic [DivCntWidth-1:0]  r_cnt;
    logic [RootCntWidth-1:0] r_rcnt;
    logic [SqWidth-1:0]      r_num, r_den;
    logic [SqWidth:0]        r_rem;
    logic [QuotWidth-1:0]    r_q;
    logic                    r_sat;
    logic [ScaleWidth-1:0]   r_root;
    logic                    r_phase;
    logic signed [CoordWidth-1:0] r_cx, r_cy;

    logic [SqWidth:0]       rem_sh;
    logic [QuotWidth:0]     q_sh;
    logic [ScaleWidth-1:0]  trial;
    logic [2*ScaleWidth-1:0] trial_sq;

    always_comb begin
        rem_sh = {r_rem[SqWidth-1:0], (r_cnt < DivCntWidth'(SqWidth)) ?
                  r_num[SqWidth-1] : 1'b0};
        q_sh = {r_q, 1'b0};
        trial = r_root | (ScaleWidth'(1) << (r_rcnt - RootCntWidth'(1)));
        trial_sq = (2*ScaleWidth)'(trial) * (2*ScaleWidth)'(trial);
    end

    always_comb begin
        n_state = r_state;
        o_job_pop = 1'b0;
        case (r_state)
            ST_IDLE: if (i_job_valid) begin
                o_job_pop = 1'b1;
                n_state = (i_job.kind == JOB_ENDED) ? ST_OUT : ST_DIV;
            end
            ST_DIV:  if (r_cnt == DivCntWidth'(DivSteps)) n_state = r_sat ? ST_OUT : ST_ROOT;
            ST_ROOT: if (r_rcnt == '0) n_state = ST_OUT;
            ST_OUT:  if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_num <= i_job.cur_sq;
                r_den <= i_job.last_sq;
                r_rem <= '0;
                r_q <= '0;
                r_sat <= 1'b0;
                r_cnt <= '0;
                r_root <= '0;
                r_rcnt <= RootCntWidth'(RootSteps);
                r_cx <= i_job.cx;
                r_cy <= i_job.cy;
                r_phase <= (i_job.kind == JOB_ENDED);
            end
            ST_DIV: if (r_cnt != DivCntWidth'(DivSteps)) begin
                r_cnt <= r_cnt + DivCntWidth'(1);
                r_num <= {r_num[SqWidth-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= rem_sh - {1'b0, r_den};
                    r_q <= q_sh[QuotWidth-1:0] | QuotWidth'(1);
                end else begin
                    r_rem <= rem_sh;
                    r_q <= q_sh[QuotWidth-1:0];
                end
                if (q_sh[QuotWidth] || r_q[QuotWidth-1]) r_sat <= 1'b1;
            end
            ST_ROOT: if (r_rcnt != '0) begin
                if (trial_sq <= r_q[2*ScaleWidth-1:0]) r_root <= trial;
                r_rcnt <= r_rcnt - RootCntWidth'(1);
            end
            default: ;
        endcase
    end

    assign o_valid = r_state == ST_OUT;
    assign o_gesture_phase = r_phase;
    assign o_center_x = r_phase ? '0 : r_cx;
    assign o_center_y = r_phase ? '0 : r_cy;
    assign o_scale = r_phase ? '0 : (r_sat || r_q[QuotWidth-1]) ? ScaleMax : r_root;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_scale))
        else $error("stalled result changed");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> r_state == ST_IDLE) else $error("pop while busy");
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gesture_phase) |-> o_scale == '0) else $error("end scale");
`endif

endmodule

[src/pinch_gesture_tracker_core.sv]
// pinch gesture tracker top level: front, job queue, back
// depends on pgt_pkg, pgt_front, pgt_queue, pgt_back
//   channel | direction | handshake
//   event   | in        | i_valid / o_stall
//   gesture | out       | o_valid / i_stall
// an event is taken when i_valid is high and o_stall is low; slots are registered as it is taken
// a scale result goes from queue head through pop, divide, root and output; the root step is
// skipped when the divide saturates; an end result goes from pop straight to output
// two-entry queue lets events continue while the back end works; input stalls when it is full
// reset clears slots, queue and back end; no clearing pass
module pinch_gesture_tracker_core import pgt_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic [3:0]                   i_touch_count,
    input  logic [IdWidth-1:0]           i_first_id,
    input  logic signed [CoordWidth-1:0] i_first_x,
    input  logic signed [CoordWidth-1:0] i_first_y,
    input  logic [IdWidth-1:0]           i_second_id,
    input  logic signed [CoordWidth-1:0] i_second_x,
    input  logic signed [CoordWidth-1:0] i_second_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_gesture_phase,
    output logic signed [CoordWidth-1:0] o_center_x,
    output logic signed [CoordWidth-1:0] o_center_y,
    output logic [ScaleWidth-1:0]        o_scale
);

    logic job_push, job_full, job_nonempty, job_pop;
    t_job job_in, job_out;

    pgt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_touch_count,
        .i_first_id, .i_first_x, .i_first_y, .i_second_id, .i_second_x, .i_second_y,
        .o_job_valid(job_push), .i_job_full(job_full), .o_job(job_in)
    );

    pgt_queue u_queue (
        .i_clk, .i_rst_n, .i_push(job_push), .i_data(job_in), .o_full(job_full),
        .o_nonempty(job_nonempty), .i_pop(job_pop), .o_data(job_out)
    );

    pgt_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_nonempty), .i_job(job_out), .o_job_pop(job_pop),
        .o_valid, .i_stall, .o_gesture_phase, .o_center_x, .o_center_y, .o_scale
    );

endmodule
